[rtl/swpf_pkg.sv]
`default_nettype none

package swpf_pkg;

	localparam int PACKET_BYTES_DEF = 32;
	localparam int HDR_LEN = 4;
	localparam int HDR_COUNT = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HDR_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_D = 2'd3;

	localparam logic ACT_FEED = 1'b0;
	localparam logic ACT_RESYNC = 1'b1;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_READ,
		ST_SHOW
	} state_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] ptype;
	} match_t;

endpackage

`default_nettype wire

[rtl/swpf_cfg_regs.sv]
`default_nettype none

module swpf_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [swpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data,
	input  wire logic [31:0]                    word,
	output swpf_pkg::match_t                    match
);

	logic [31:0] hdr_a_q;
	logic [31:0] hdr_b_q;
	logic [31:0] hdr_c_q;
	logic [31:0] hdr_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_a_q <= '0;
			hdr_b_q <= '0;
			hdr_c_q <= '0;
			hdr_d_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				swpf_pkg::CFG_HDR_A: hdr_a_q <= cfg_data;
				swpf_pkg::CFG_HDR_B: hdr_b_q <= cfg_data;
				swpf_pkg::CFG_HDR_C: hdr_c_q <= cfg_data;
				swpf_pkg::CFG_HDR_D: hdr_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The lowest header index wins when several words are equal.
	always_comb begin
		match.hit = 1'b1;
		if (word == hdr_a_q) begin
			match.ptype = 2'd0;
		end else if (word == hdr_b_q) begin
			match.ptype = 2'd1;
		end else if (word == hdr_c_q) begin
			match.ptype = 2'd2;
		end else if (word == hdr_d_q) begin
			match.ptype = 2'd3;
		end else begin
			match.hit = 1'b0;
			match.ptype = 2'd0;
		end
	end

endmodule

`default_nettype wire

[rtl/swpf_store.sv]
`default_nettype none

module swpf_store #(
	parameter int DEPTH = swpf_pkg::PACKET_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/sync_word_packet_framer_unit.sv]
`default_nettype none

// Channel   Direction  Handshake             Beat contents
// in        input      in_valid / in_stall   action, data_byte
// out       output     out_valid / out_stall packet_type, packet_byte, last_byte
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Input beats are accepted without stall while the framer hunts or collects.
// The beat that completes a packet starts a run of PACKET_BYTES output beats,
// each made of a packet store read (READ state) and an output (SHOW state).
// The input is stalled for the whole run. Output stalls stretch the run.
// Reset clears progress and the header words; the store needs no clearing.

module sync_word_packet_framer_unit #(
	parameter int PACKET_BYTES = swpf_pkg::PACKET_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           action,
	input  wire logic [7:0]                     data_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [1:0]                     packet_type,
	output logic      [7:0]                     packet_byte,
	output logic                                last_byte,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [swpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	localparam int AW = $clog2(PACKET_BYTES);
	localparam logic [AW-1:0] LAST_IDX = AW'(PACKET_BYTES - 1);
	localparam logic [AW-1:0] HUNT_TOP = AW'(swpf_pkg::HDR_LEN - 1);
	localparam logic [AW-1:0] HDR_END = AW'(swpf_pkg::HDR_LEN);

	swpf_pkg::state_t state_q;
	swpf_pkg::state_t state_d;
	swpf_pkg::match_t match;

	logic [AW-1:0] fill_q;
	logic [AW-1:0] idx_q;
	logic          sync_q;
	logic [1:0]    type_q;
	logic [31:0]   win_q;
	logic [31:0]   cand;
	logic [7:0]    rd_data;
	logic          in_acc;
	logic          feed;
	logic          store_we;
	logic          store_re;
	logic          out_acc;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != swpf_pkg::ST_COLLECT);
	assign in_acc = in_valid && !in_stall;
	assign feed = in_acc && (action == swpf_pkg::ACT_FEED);
	assign out_acc = out_valid && !out_stall;
	assign cand = {data_byte, win_q[31:8]};
	assign store_we = feed && sync_q;
	assign store_re = (state_q == swpf_pkg::ST_READ);

	swpf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.word      (cand),
		.match     (match)
	);

	swpf_store #(
		.DEPTH (PACKET_BYTES)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (fill_q),
		.wdata (data_byte),
		.re    (store_re),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swpf_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		out_valid = 1'b0;
		case (state_q)
			swpf_pkg::ST_COLLECT: begin
				if (store_we && fill_q == LAST_IDX) begin
					state_d = swpf_pkg::ST_READ;
				end
			end
			swpf_pkg::ST_READ: begin
				state_d = swpf_pkg::ST_SHOW;
			end
			swpf_pkg::ST_SHOW: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = (idx_q == LAST_IDX) ? swpf_pkg::ST_COLLECT : swpf_pkg::ST_READ;
				end
			end
			default: begin
				state_d = swpf_pkg::ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sync_q <= 1'b0;
			type_q <= '0;
			idx_q <= '0;
		end else begin
			if (in_acc && action == swpf_pkg::ACT_RESYNC) begin
				fill_q <= '0;
				sync_q <= 1'b0;
				type_q <= '0;
			end else if (feed && !sync_q) begin
				if (fill_q != HUNT_TOP) begin
					fill_q <= fill_q + AW'(1);
				end else if (match.hit) begin
					fill_q <= HDR_END;
					sync_q <= 1'b1;
					type_q <= match.ptype;
				end
			end else if (store_we) begin
				if (fill_q == LAST_IDX) begin
					fill_q <= '0;
					sync_q <= 1'b0;
					idx_q <= '0;
				end else begin
					fill_q <= fill_q + AW'(1);
				end
			end
			if (out_acc && idx_q != LAST_IDX) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	// The window shifts in at the top, so the oldest byte ends up least significant.
	always_ff @(posedge clk) begin
		if (feed && !sync_q) begin
			win_q <= cand;
		end
	end

	assign packet_type = type_q;
	assign last_byte = (idx_q == LAST_IDX);
	assign packet_byte = (idx_q < HDR_END) ? win_q[idx_q[1:0]*8 +: 8] : rd_data;

	a_hunt_window: assert property (@(posedge clk) disable iff (!arst_n)
		!sync_q |-> fill_q <= HUNT_TOP)
		else $error("hunt fill count beyond window");

	a_sync_fill: assert property (@(posedge clk) disable iff (!arst_n)
		sync_q |-> fill_q >= HDR_END)
		else $error("in sync without a full header held");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_byte) |=> (state_q == swpf_pkg::ST_COLLECT && !sync_q))
		else $error("run did not end in collect state");

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_stall && fill_q == '0))
		else $error("input open or progress held during packet run");

endmodule

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
	import swpf_pkg::*;

	localparam int PKT = PACKET_BYTES_DEF;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic       act;
		logic [7:0] data;
	} stream_item_t;

	typedef struct packed {
		logic [1:0] ptype;
		logic [7:0] pbyte;
		logic       last;
	} packet_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 action = ACT_FEED;
	logic [7:0]           data_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           packet_type;
	logic [7:0]           packet_byte;
	logic                 last_byte;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HDR_A;
	logic [31:0]          cfg_data = 32'h0;

	stream_item_t byte_stream_q[$];
	packet_beat_t due_beats_q[$];
	stream_item_t next_item;
	packet_beat_t due_beat;

	logic [31:0] header_words [HDR_COUNT] = '{default: 32'h0};
	logic [7:0]  held_bytes [PKT];
	int          held_count = 0;
	logic        locked = 1'b0;
	logic [1:0]  locked_type = 2'd0;

	int idle_pct = 30;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int mismatches = 0;

	sync_word_packet_framer_unit #(
		.PACKET_BYTES(PKT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packet_type(packet_type),
		.packet_byte(packet_byte),
		.last_byte(last_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	task automatic advance_framer(input stream_item_t item);
		logic [31:0] word;
		logic        hit;
		logic [1:0]  hit_type;
		int          k;
		if (item.act == ACT_RESYNC) begin
			held_count = 0;
			locked = 1'b0;
			locked_type = 2'd0;
			return;
		end
		if (held_count < PKT) begin
			held_bytes[held_count] = item.data;
			held_count++;
		end
		if (held_count < HDR_LEN)
			return;
		if (!locked) begin
			word = {held_bytes[3], held_bytes[2], held_bytes[1], held_bytes[0]};
			hit = 1'b0;
			hit_type = 2'd0;
			// Scanning downward leaves the lowest matching type in place.
			for (k = HDR_COUNT - 1; k >= 0; k--) begin
				if (word == header_words[k]) begin
					hit = 1'b1;
					hit_type = k[1:0];
				end
			end
			if (!hit) begin
				for (k = 0; k < held_count - 1; k++)
					held_bytes[k] = held_bytes[k + 1];
				held_count--;
				return;
			end
			locked = 1'b1;
			locked_type = hit_type;
		end
		if (held_count < PKT)
			return;
		for (k = 0; k < PKT; k++)
			due_beats_q.push_back('{locked_type, held_bytes[k], k == PKT - 1});
		held_count = 0;
		locked = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				advance_framer('{action, data_byte});
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (byte_stream_q.size() > 0) begin
					next_item = byte_stream_q.pop_front();
					in_valid <= 1'b1;
					action <= next_item.act;
					data_byte <= next_item.data;
					if ($urandom_range(99) < idle_pct)
						send_gap = $urandom_range(1, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_beats_q.size() == 0) begin
					$display("%0t: beat with nothing due: type %0d byte %02h last %0b",
						$time, packet_type, packet_byte, last_byte);
					mismatches++;
				end else begin
					due_beat = due_beats_q.pop_front();
					if (due_beat !== {packet_type, packet_byte, last_byte}) begin
						$display("%0t: expected type %0d byte %02h last %0b, got type %0d byte %02h last %0b",
							$time, due_beat.ptype, due_beat.pbyte, due_beat.last,
							packet_type, packet_byte, last_byte);
						mismatches++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if ($urandom_range(99) < idle_pct) begin
				recv_gap = $urandom_range(0, 17);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_byte(input logic act, input logic [7:0] b);
		byte_stream_q.push_back('{act, b});
	endtask

	task automatic queue_header(input int k);
		int j;
		for (j = 0; j < HDR_LEN; j++)
			queue_byte(ACT_FEED, header_words[k][8 * j +: 8]);
	endtask

	task automatic queue_payload(input int n);
		repeat (n) queue_byte(ACT_FEED, 8'($urandom));
	endtask

	// Random noise, a header taken from the current set, then either a full
	// packet or a truncated one that ends in a resync.
	task automatic queue_frame(input int noise, input bit cut);
		queue_payload(noise);
		queue_header($urandom_range(HDR_COUNT - 1));
		if (cut) begin
			queue_payload($urandom_range(0, PKT - HDR_LEN - 1));
			queue_byte(ACT_RESYNC, 8'($urandom));
		end else begin
			queue_payload(PKT - HDR_LEN);
		end
	endtask

	task automatic write_header(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		header_words[idx] = val;
	endtask

	task automatic write_headers(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		write_header(CFG_HDR_A, a);
		write_header(CFG_HDR_B, b);
		write_header(CFG_HDR_C, c);
		write_header(CFG_HDR_D, d);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (byte_stream_q.size() != 0 || in_valid || due_beats_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All header words are zero after reset, so four zero bytes match type 0.
		queue_byte(ACT_FEED, 8'hFF);
		queue_byte(ACT_FEED, 8'h80);
		queue_byte(ACT_FEED, 8'h01);
		queue_byte(ACT_RESYNC, 8'hFF);
		repeat (HDR_LEN) queue_byte(ACT_FEED, 8'h00);
		queue_byte(ACT_FEED, 8'hFF);
		queue_byte(ACT_FEED, 8'h00);
		queue_byte(ACT_FEED, 8'hAA);
		queue_byte(ACT_FEED, 8'h55);
		queue_payload(PKT - HDR_LEN - 4);
		wait_idle();

		write_headers(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0001);
		queue_header(2);
		queue_payload(PKT - HDR_LEN);
		queue_header(0);
		queue_payload(5);
		wait_idle();
		// New header words mid-packet must not change the latched type.
		write_headers($urandom, $urandom, $urandom, $urandom);
		queue_payload(PKT - HDR_LEN - 5);
		queue_header(3);
		queue_payload(6);
		queue_byte(ACT_RESYNC, 8'h00);
		wait_idle();

		// The receiver holds off long enough for the input side to back up.
		idle_pct = 0;
		hold_requests++;
		queue_frame($urandom_range(0, 3), 1'b0);
		queue_payload(HDR_LEN);
		wait_idle();

		write_headers($urandom, $urandom, $urandom, 32'h0000_0000);
		queue_frame($urandom_range(0, 4), 1'b0);
		wait_idle();

		if (mismatches == 0 && due_beats_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/swpf_pkg.sv
rtl/swpf_cfg_regs.sv
rtl/swpf_store.sv
rtl/sync_word_packet_framer_unit.sv
verif/tb_top.sv
